FILE: rtl/core/tbd_pkg.sv
// ----------------------------------------------------------------------------
// Tile box downsampler package
// Shared field widths, payload structs and handshake control for the block.
// ----------------------------------------------------------------------------
`default_nettype none

package tbd_pkg;

    localparam int PIXEL_W  = 32;
    localparam int CHAN_W   = 8;
    localparam int ZOOM_W   = 3;
    localparam int BLKIDX_W = 4;
    localparam int MAX_ZOOM = 4;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [CHAN_W-1:0]   avg_red;
        logic [CHAN_W-1:0]   avg_green;
        logic [CHAN_W-1:0]   avg_blue;
        logic [BLKIDX_W-1:0] block_col;
        logic [BLKIDX_W-1:0] block_row;
        logic                tile_done;
    } t_result;

    typedef struct packed {
        logic take;
        logic emit;
    } t_stage_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/tbd_if.sv
// ----------------------------------------------------------------------------
// Tile box downsampler channels
// Valid/ready interfaces for pixels, block results and the zoom register.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbd_pixel_if;
    import tbd_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_word;
    modport source (output valid, output pixel_word, input ready);
    modport sink   (input valid, input pixel_word, output ready);
endinterface

interface tbd_result_if;
    import tbd_pkg::*;
    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   avg_red;
    logic [CHAN_W-1:0]   avg_green;
    logic [CHAN_W-1:0]   avg_blue;
    logic [BLKIDX_W-1:0] block_col;
    logic [BLKIDX_W-1:0] block_row;
    logic                tile_done;
    modport source (output valid, output avg_red, output avg_green, output avg_blue,
                    output block_col, output block_row, output tile_done, input ready);
    modport sink   (input valid, input avg_red, input avg_green, input avg_blue,
                    input block_col, input block_row, input tile_done, output ready);
endinterface

interface tbd_cfg_if;
    import tbd_pkg::*;
    logic              valid;
    logic              ready;
    logic [ZOOM_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tbd_input_stage.sv
// ----------------------------------------------------------------------------
// Tile box downsampler input stage
// Registers each pixel item with its position and advances the raster counter.
// ----------------------------------------------------------------------------
`default_nettype none

module tbd_input_stage #(
    parameter int TILE_SIDE_LOG2 = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [tbd_pkg::PIXEL_W-1:0] i_pixel_word,
    input  wire logic                        i_clear,
    input  wire tbd_pkg::t_stage_ctl         i_ctl,
    output logic                             o_vld,
    output tbd_pkg::t_rgb                    o_rgb,
    output logic [TILE_SIDE_LOG2-1:0]        o_col,
    output logic [TILE_SIDE_LOG2-1:0]        o_row
);
    import tbd_pkg::*;

    localparam int POS_W = 2 * TILE_SIDE_LOG2;

    logic [POS_W-1:0]          r_pos;
    logic [POS_W-1:0]          n_pos;
    logic                      r_vld;
    logic                      n_vld;
    t_rgb                      r_rgb;
    logic [TILE_SIDE_LOG2-1:0] r_col;
    logic [TILE_SIDE_LOG2-1:0] r_row;
    logic                      accept;

    assign o_ready = !r_vld || i_ctl.take;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_pos = r_pos;
        n_vld = r_vld;
        if (i_ctl.take) begin
            n_vld = 1'b0;
        end
        if (accept) begin
            n_vld = 1'b1;
            n_pos = r_pos + POS_W'(1);
        end
        if (i_clear) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vld <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rgb.red   <= i_pixel_word[23:16];
            r_rgb.green <= i_pixel_word[15:8];
            r_rgb.blue  <= i_pixel_word[7:0];
            r_col       <= r_pos[TILE_SIDE_LOG2-1:0];
            r_row       <= r_pos[POS_W-1:TILE_SIDE_LOG2];
        end
    end

    assign o_vld = r_vld;
    assign o_rgb = r_rgb;
    assign o_col = r_col;
    assign o_row = r_row;

endmodule

`default_nettype wire

FILE: rtl/core/tbd_col_accum.sv
// ----------------------------------------------------------------------------
// Tile box downsampler column accumulator
// Keeps per block column channel sums and registers each finished block mean.
// ----------------------------------------------------------------------------
`default_nettype none

module tbd_col_accum #(
    parameter int TILE_SIDE_LOG2 = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [tbd_pkg::ZOOM_W-1:0] i_zoom,
    input  wire logic                       i_vld,
    input  wire tbd_pkg::t_rgb              i_rgb,
    input  wire logic [TILE_SIDE_LOG2-1:0]  i_col,
    input  wire logic [TILE_SIDE_LOG2-1:0]  i_row,
    output tbd_pkg::t_stage_ctl             o_ctl,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output tbd_pkg::t_result                o_res
);
    import tbd_pkg::*;

    localparam int MAX_EZ  = (TILE_SIDE_LOG2 < MAX_ZOOM) ? TILE_SIDE_LOG2 : MAX_ZOOM;
    localparam int ZE_W    = $clog2(MAX_EZ + 1);
    localparam int CIDX_W  = MAX_EZ;
    localparam int NCOL    = 1 << CIDX_W;
    localparam int BLOG_W  = $clog2(TILE_SIDE_LOG2 + 1);
    localparam int SUM_W   = CHAN_W + 2 * TILE_SIDE_LOG2;
    localparam logic [TILE_SIDE_LOG2-1:0] SIDE_MASK = '1;

    logic [SUM_W-1:0]          r_red_sum   [NCOL];
    logic [SUM_W-1:0]          r_green_sum [NCOL];
    logic [SUM_W-1:0]          r_blue_sum  [NCOL];
    logic [ZE_W-1:0]           r_zoom_eff;
    logic                      r_out_vld;
    t_result                   r_res;

    logic [ZE_W-1:0]           zoom_eff;
    logic [BLOG_W-1:0]         blog;
    logic [BLOG_W:0]           shamt;
    logic [TILE_SIDE_LOG2-1:0] bmask;
    logic [TILE_SIDE_LOG2-1:0] bcol;
    logic [TILE_SIDE_LOG2-1:0] brow;
    logic [CIDX_W-1:0]         idx;
    logic [SUM_W-1:0]          red_sum;
    logic [SUM_W-1:0]          green_sum;
    logic [SUM_W-1:0]          blue_sum;
    logic                      emit;
    logic                      out_free;
    logic                      take;
    t_result                   res;

    assign zoom_eff = (i_zoom > ZOOM_W'(MAX_EZ)) ? ZE_W'(MAX_EZ) : ZE_W'(i_zoom);

    assign blog   = BLOG_W'(TILE_SIDE_LOG2) - BLOG_W'(r_zoom_eff);
    assign shamt  = {blog, 1'b0};
    assign bmask  = SIDE_MASK >> r_zoom_eff;
    assign bcol   = i_col >> blog;
    assign brow   = i_row >> blog;
    assign idx    = bcol[CIDX_W-1:0];

    assign red_sum   = r_red_sum[idx]   + SUM_W'(i_rgb.red);
    assign green_sum = r_green_sum[idx] + SUM_W'(i_rgb.green);
    assign blue_sum  = r_blue_sum[idx]  + SUM_W'(i_rgb.blue);

    assign emit     = ((i_col & bmask) == bmask) && ((i_row & bmask) == bmask);
    assign out_free = !r_out_vld || i_ready;
    assign take     = i_vld && (!emit || out_free);

    always_comb begin
        res.avg_red   = CHAN_W'(red_sum >> shamt);
        res.avg_green = CHAN_W'(green_sum >> shamt);
        res.avg_blue  = CHAN_W'(blue_sum >> shamt);
        res.block_col = BLKIDX_W'(idx);
        res.block_row = BLKIDX_W'(brow);
        res.tile_done = (i_col == SIDE_MASK) && (i_row == SIDE_MASK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom_eff <= '0;
            r_out_vld  <= 1'b0;
            for (int i = 0; i < NCOL; i++) begin
                r_red_sum[i]   <= '0;
                r_green_sum[i] <= '0;
                r_blue_sum[i]  <= '0;
            end
        end else begin
            if (take && emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                r_zoom_eff <= zoom_eff;
                for (int i = 0; i < NCOL; i++) begin
                    r_red_sum[i]   <= '0;
                    r_green_sum[i] <= '0;
                    r_blue_sum[i]  <= '0;
                end
            end else if (take) begin
                r_red_sum[idx]   <= emit ? '0 : red_sum;
                r_green_sum[idx] <= emit ? '0 : green_sum;
                r_blue_sum[idx]  <= emit ? '0 : blue_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_res <= res;
        end
    end

    assign o_ctl.take = take;
    assign o_ctl.emit = emit;
    assign o_valid    = r_out_vld;
    assign o_res      = r_res;

endmodule

`default_nettype wire

FILE: rtl/core/tile_box_downsampler_top.sv
// ----------------------------------------------------------------------------
// Tile box downsampler
// Averages square power-of-two blocks of a raster-order ARGB tile.
// Pixels are registered in the input stage and block results in the output register.
// Throughput is one pixel per cycle unless a finished block waits on a held result output.
// Reset is synchronous and clears zoom, sums, position and both stage valids.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_box_downsampler_top #(
    parameter int TILE_SIDE_LOG2 = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tbd_pixel_if.sink    i_pix,
    tbd_result_if.source o_res,
    tbd_cfg_if.sink      i_cfg
);
    import tbd_pkg::*;

    logic                      cfg_we;
    t_stage_ctl                ctl;
    logic                      s1_vld;
    t_rgb                      s1_rgb;
    logic [TILE_SIDE_LOG2-1:0] s1_col;
    logic [TILE_SIDE_LOG2-1:0] s1_row;
    t_result                   res;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    tbd_input_stage #(
        .TILE_SIDE_LOG2(TILE_SIDE_LOG2)
    ) u_input_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_pix.valid),
        .o_ready     (i_pix.ready),
        .i_pixel_word(i_pix.pixel_word),
        .i_clear     (cfg_we),
        .i_ctl       (ctl),
        .o_vld       (s1_vld),
        .o_rgb       (s1_rgb),
        .o_col       (s1_col),
        .o_row       (s1_row)
    );

    tbd_col_accum #(
        .TILE_SIDE_LOG2(TILE_SIDE_LOG2)
    ) u_col_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg_we(cfg_we),
        .i_zoom  (i_cfg.data),
        .i_vld   (s1_vld),
        .i_rgb   (s1_rgb),
        .i_col   (s1_col),
        .i_row   (s1_row),
        .o_ctl   (ctl),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_res   (res)
    );

    assign o_res.avg_red   = res.avg_red;
    assign o_res.avg_green = res.avg_green;
    assign o_res.avg_blue  = res.avg_blue;
    assign o_res.block_col = res.block_col;
    assign o_res.block_row = res.block_row;
    assign o_res.tile_done = res.tile_done;

    // The last block of a tile sits on the diagonal.
    a_tile_done_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.tile_done |-> o_res.block_col == o_res.block_row)
        else $error("tile_done on a block off the diagonal");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.take && ctl.emit |=> o_res.valid)
        else $error("finished block did not reach the output register");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_vld && !ctl.take |=> s1_vld)
        else $error("input stage dropped an item that was not taken");

endmodule

`default_nettype wire

FILE: test/tile_box_downsampler_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tile box downsampler testbench
// Streams raster-order tiles through the block at directed and random zoom settings,
// including zoom values that saturate and rewrites part-way through a tile.
// A local model predicts each block mean, and every result item is checked
// in order against it. Both channels idle at random, and a long receiver
// hold-off fills the block up so that it stalls its pixel input.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_box_downsampler_top_test;

    import tbd_pkg::*;

    localparam int TILE_LOG2    = 4;
    localparam int SUM_W        = CHAN_W + 2 * TILE_LOG2;
    localparam int NUM_COLS     = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 150;
    localparam int MAX_REPORTS  = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tbd_pixel_if  pix_ch();
    tbd_result_if res_ch();
    tbd_cfg_if    cfg_ch();

    tile_box_downsampler_top #(
        .TILE_SIDE_LOG2(TILE_LOG2)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [ZOOM_W-1:0]   zoom_reg;
    logic [SUM_W-1:0]    red_acc   [NUM_COLS];
    logic [SUM_W-1:0]    green_acc [NUM_COLS];
    logic [SUM_W-1:0]    blue_acc  [NUM_COLS];
    logic [TILE_LOG2-1:0] pix_col;
    logic [TILE_LOG2-1:0] pix_row;
    t_result             pending_means[$];

    int n_errors    = 0;
    int idle_cycles = 0;
    bit src_idle_on = 1'b0;
    bit snk_idle_on = 1'b0;
    bit hold_req    = 1'b0;

    function automatic void clear_tile_model();
        for (int i = 0; i < NUM_COLS; i++) begin
            red_acc[i]   = '0;
            green_acc[i] = '0;
            blue_acc[i]  = '0;
        end
        pix_col = '0;
        pix_row = '0;
    endfunction

    function automatic void accumulate_pixel(input logic [PIXEL_W-1:0] word);
        int                   zoom_eff;
        int                   blk_log2;
        int                   shift;
        logic [TILE_LOG2-1:0] blk_mask;
        logic [BLKIDX_W-1:0]  bcol;
        logic [BLKIDX_W-1:0]  brow;
        t_result              mean;
        zoom_eff = (zoom_reg > MAX_ZOOM) ? MAX_ZOOM : int'(zoom_reg);
        if (zoom_eff > TILE_LOG2) begin
            zoom_eff = TILE_LOG2;
        end
        blk_log2 = TILE_LOG2 - zoom_eff;
        blk_mask = TILE_LOG2'((1 << blk_log2) - 1);
        bcol     = BLKIDX_W'(pix_col >> blk_log2);
        brow     = BLKIDX_W'(pix_row >> blk_log2);
        red_acc[bcol]   = red_acc[bcol]   + SUM_W'(word[23:16]);
        green_acc[bcol] = green_acc[bcol] + SUM_W'(word[15:8]);
        blue_acc[bcol]  = blue_acc[bcol]  + SUM_W'(word[7:0]);
        if ((pix_col & blk_mask) == blk_mask && (pix_row & blk_mask) == blk_mask) begin
            shift           = 2 * blk_log2;
            mean.avg_red    = CHAN_W'(red_acc[bcol] >> shift);
            mean.avg_green  = CHAN_W'(green_acc[bcol] >> shift);
            mean.avg_blue   = CHAN_W'(blue_acc[bcol] >> shift);
            mean.block_col  = bcol;
            mean.block_row  = brow;
            mean.tile_done  = (&pix_col) && (&pix_row);
            pending_means.insert(pending_means.size(), mean);
            red_acc[bcol]   = '0;
            green_acc[bcol] = '0;
            blue_acc[bcol]  = '0;
        end
        if (&pix_col) begin
            pix_col = '0;
            pix_row = pix_row + TILE_LOG2'(1);
        end else begin
            pix_col = pix_col + TILE_LOG2'(1);
        end
    endfunction

    function automatic void check_block_mean(input t_result got);
        t_result want;
        if (pending_means.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
                $display("unexpected result item: red %0d green %0d blue %0d col %0d row %0d done %0d",
                         got.avg_red, got.avg_green, got.avg_blue,
                         got.block_col, got.block_row, got.tile_done);
            end
        end else begin
            want = pending_means.pop_front();
            if (got.avg_red !== want.avg_red || got.avg_green !== want.avg_green ||
                got.avg_blue !== want.avg_blue || got.block_col !== want.block_col ||
                got.block_row !== want.block_row || got.tile_done !== want.tile_done) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $display("mismatch: expected red %0d green %0d blue %0d col %0d row %0d done %0d",
                             want.avg_red, want.avg_green, want.avg_blue,
                             want.block_col, want.block_row, want.tile_done);
                    $display("          actual   red %0d green %0d blue %0d col %0d row %0d done %0d",
                             got.avg_red, got.avg_green, got.avg_blue,
                             got.block_col, got.block_row, got.tile_done);
                end
            end
        end
    endfunction

    // Results are checked before the pixel of the same edge is predicted.
    always @(posedge i_clk) begin
        t_result got;
        bit      moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (res_ch.valid && res_ch.ready) begin
                got.avg_red   = res_ch.avg_red;
                got.avg_green = res_ch.avg_green;
                got.avg_blue  = res_ch.avg_blue;
                got.block_col = res_ch.block_col;
                got.block_row = res_ch.block_row;
                got.tile_done = res_ch.tile_done;
                check_block_mean(got);
                moved = 1'b1;
            end
            if (pix_ch.valid && pix_ch.ready) begin
                accumulate_pixel(pix_ch.pixel_word);
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                zoom_reg = cfg_ch.data;
                clear_tile_model();
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tile_box_downsampler_top test failed");
                $finish;
            end
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] word);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.pixel_word <= word;
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    task automatic wait_for_means();
        pix_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_zoom(input logic [ZOOM_W-1:0] zoom);
        wait_for_means();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= zoom;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [PIXEL_W-1:0] make_pixel(input int mode);
        logic [PIXEL_W-1:0] word;
        word = $urandom;
        case (mode)
            1: begin
                word[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                word[15:8]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                word[7:0]   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            2: begin
                word[23:16] = 8'hF0 | 8'($urandom_range(0, 15));
                word[15:8]  = 8'hF0 | 8'($urandom_range(0, 15));
                word[7:0]   = 8'hF0 | 8'($urandom_range(0, 15));
            end
            3: begin
                word[23:0] = 24'(word[23:0] & 24'h0F0F0F);
            end
            4: begin
                word = 32'hFFFFFFFF;
            end
            default: begin
            end
        endcase
        return word;
    endfunction

    task automatic test_directed_extremes();
        logic [PIXEL_W-1:0] words[16];
        words = '{32'h00000000, 32'hFFFFFFFF, 32'hFF000000, 32'h00FF0000,
                  32'h0000FF00, 32'h000000FF, 32'h00FFFFFF, 32'hFF00FF00,
                  32'h00FF00FF, 32'hAA55AA55, 32'h55AA55AA, 32'h80808080,
                  32'h7F7F7F7F, 32'h01010101, 32'hFEFEFEFE, 32'h12345678};
        write_zoom(ZOOM_W'(MAX_ZOOM));
        foreach (words[i]) begin
            send_pixel(words[i]);
        end
    endtask

    task automatic test_zoom_saturation();
        write_zoom(3'd5);
        repeat (3) send_pixel($urandom);
        write_zoom(3'd7);
        repeat (3) send_pixel($urandom);
    endtask

    task automatic test_mid_tile_rewrite();
        write_zoom(3'd1);
        repeat (3) send_pixel($urandom);
        write_zoom(ZOOM_W'(MAX_ZOOM));
        repeat (2) send_pixel($urandom);
    endtask

    task automatic test_backpressure();
        write_zoom(ZOOM_W'(MAX_ZOOM));
        hold_req = 1'b1;
        repeat (64) send_pixel($urandom);
    endtask

    task automatic test_random_tiles();
        int sent;
        int count;
        int mode;
        logic [ZOOM_W-1:0] zoom;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        sent = 0;
        write_zoom(3'd0);
        repeat (256) send_pixel(make_pixel(4));
        while (sent < RANDOM_ITEMS) begin
            zoom  = ZOOM_W'($urandom_range(0, 7));
            count = $urandom_range(0, 1) ? 256 : $urandom_range(1, 300);
            mode  = $urandom_range(0, 3);
            write_zoom(zoom);
            repeat (count) send_pixel(make_pixel(mode));
            sent += count;
        end
    endtask

    task automatic test_steady_stream();
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        write_zoom(3'd2);
        repeat (64) send_pixel(make_pixel(0));
        write_zoom(ZOOM_W'(MAX_ZOOM));
        repeat (64) send_pixel(make_pixel(1));
    endtask

    initial begin
        zoom_reg = '0;
        clear_tile_model();
        i_rst_n           <= 1'b0;
        pix_ch.valid      <= 1'b0;
        pix_ch.pixel_word <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_zoom_saturation();
        test_mid_tile_rewrite();
        test_backpressure();
        test_random_tiles();
        test_steady_stream();

        wait_for_means();
        if (n_errors == 0 && pending_means.size() == 0) begin
            $display("tile_box_downsampler_top test passed");
        end else begin
            $display("tile_box_downsampler_top test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
